// File: rtl/pll_divider_planner_unit_defines.svh
// assertion macros shared by the planner rtl
`ifndef PLL_DIVIDER_PLANNER_UNIT_DEFINES_SVH
`define PLL_DIVIDER_PLANNER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define PDP_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, held off during reset
`define PDP_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/pdp_pkg.sv
package pdp_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned REQ_W    = 32;
  localparam int unsigned RATE_W   = 36;
  localparam int unsigned FB_W     = 9;
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned GAIN_W   = 3;
  localparam int unsigned CUR_W    = 3;
  localparam int unsigned PARENT_W = 27;
  localparam int unsigned RD_W     = 5;
  localparam int unsigned MHZ_W    = 13;
  localparam int unsigned VCO_W    = 12;
  localparam int unsigned PMHZ_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // serial divider geometry
  localparam int unsigned DIV_W = 36;
  localparam int unsigned DVS_W = 20;
  localparam int unsigned LEN_W = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OP_W-1:0] OP_ROUND = 2'd1;
  localparam logic [OP_W-1:0] OP_SET   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_DIV     = 1'b1;

  // post divider select codes
  localparam logic [SEL_W-1:0] SEL_DIV1 = 4'd0;
  localparam logic [SEL_W-1:0] SEL_DIV2 = 4'd2;
  localparam logic [SEL_W-1:0] SEL_DIV4 = 4'd5;
  localparam logic [SEL_W-1:0] SEL_DIV8 = 4'd8;

  localparam logic [DVS_W-1:0] MHZ_HZ = 20'd1000000;

  // band limits in MHz
  localparam logic [MHZ_W-1:0] VCO_MIN   = 13'd1200;
  localparam logic [MHZ_W-1:0] VCO_MAX   = 13'd2500;
  localparam logic [MHZ_W-1:0] BAND2_MIN = 13'd600;
  localparam logic [MHZ_W-1:0] BAND4_MIN = 13'd300;
  localparam logic [MHZ_W-1:0] BAND8_MIN = 13'd150;

  localparam logic [PARENT_W-1:0] PARENT_RST = 27'd25000000;
  localparam logic [RD_W-1:0]     RD_RST     = 5'd1;

  // division lengths in cycles, one quotient bit each
  localparam logic [LEN_W-1:0] LEN_MHZ  = 6'd32;
  localparam logic [LEN_W-1:0] LEN_PMHZ = 6'd27;
  localparam logic [LEN_W-1:0] LEN_FB   = 6'd17;
  localparam logic [LEN_W-1:0] LEN_RATE = 6'd36;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } pdp_div_req_t;

  // log2 of the post divide; only the four legal codes are ever stored
  function automatic logic [1:0] post_shift(input logic [SEL_W-1:0] sel);
    logic [1:0] sh;
    unique case (sel)
      SEL_DIV2: sh = 2'd1;
      SEL_DIV4: sh = 2'd2;
      SEL_DIV8: sh = 2'd3;
      default:  sh = 2'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_of(input logic [VCO_W-1:0] vco);
    logic [GAIN_W-1:0] g;
    priority if (vco <= 12'd1350) g = 3'd1;
    else if (vco <= 12'd1550) g = 3'd2;
    else if (vco <= 12'd1750) g = 3'd3;
    else if (vco <= 12'd1950) g = 3'd4;
    else if (vco <= 12'd2150) g = 3'd5;
    else if (vco <= 12'd2400) g = 3'd6;
    else g = 3'd7;
    return g;
  endfunction

  function automatic logic [CUR_W-1:0] current_of(input logic [VCO_W-1:0] vco);
    logic [CUR_W-1:0] c;
    priority if (vco <= 12'd1500) c = 3'd2;
    else if (vco <= 12'd1800) c = 3'd3;
    else if (vco <= 12'd2100) c = 3'd4;
    else if (vco <= 12'd2400) c = 3'd5;
    else c = 3'd6;
    return c;
  endfunction

endpackage

// File: rtl/pdp_in_if.sv
interface pdp_in_if import pdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [REQ_W-1:0] requested_rate_hz;

  modport source (output valid, output operation, output requested_rate_hz, input ready);
  modport sink   (input valid, input operation, input requested_rate_hz, output ready);
endinterface

// File: rtl/pdp_out_if.sv
interface pdp_out_if import pdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_hz;
  logic [FB_W-1:0]   feedback_div;
  logic [SEL_W-1:0]  post_div_select;
  logic [GAIN_W-1:0] vco_gain_band;
  logic [CUR_W-1:0]  loop_current_code;
  logic              status;

  modport source (output valid, output rate_hz, output feedback_div, output post_div_select,
                  output vco_gain_band, output loop_current_code, output status,
                  input ready);
  modport sink   (input valid, input rate_hz, input feedback_div, input post_div_select,
                  input vco_gain_band, input loop_current_code, input status,
                  output ready);
endinterface

// File: rtl/pdp_serdiv.sv
module pdp_serdiv import pdp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdp_div_req_t       req_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DIV_W-1:0]   quot_o
);

  // restoring divider, one quotient bit per cycle
  // the dividend arrives left-aligned; after len steps acc holds the quotient
  logic [LEN_W-1:0] cnt_q;
  logic             done_q;
  logic [DIV_W-1:0] acc_q;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  // trial subtract
  always_comb begin
    trial = {rem_q, acc_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // step counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == LEN_W'(1));
      if (req_i.start) begin
        cnt_q <= req_i.len;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - LEN_W'(1);
      end
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// File: rtl/pll_divider_planner_unit.sv
// PLL divider planner. Each transfer on req_i carries an operation (query, round or set) and a
// requested rate in Hz. Exactly one result transfer follows on rsp_o. All divisions share one
// restoring divider that retires one quotient bit per cycle, so the divisions an operation
// needs set its latency. The divisions that each operation runs:
// - a query, or unused code 3: one 36-bit rate division
// - a round or set outside the supported bands: the 32-bit MHz division plus the rate division
// - a round or set in band: MHz, parent MHz, feedback and rate divisions of 32, 27, 17 and 36
//   bits, or without the feedback division when the parent is below one MHz
// A zero reference divider skips the rate division. One request is in flight at a time. A new
// request can be taken once the previous result has landed in the output register. A stalled
// result holds the sequencer until the output register frees. Configuration writes on
// cfg_we_i must happen only while no request is outstanding.
`include "pll_divider_planner_unit_defines.svh"

module pll_divider_planner_unit import pdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PARENT_W-1:0]  cfg_wdata_i,
  pdp_in_if.sink               req_i,
  pdp_out_if.source            rsp_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MHZ    = 3'd1;
  localparam logic [2:0] S_PMHZ   = 3'd2;
  localparam logic [2:0] S_FB     = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_RSTART = 3'd5;
  localparam logic [2:0] S_RATE   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  // configuration and stored settings
  logic [PARENT_W-1:0] parent_q;
  logic [RD_W-1:0]     rd_q;
  logic [FB_W-1:0]     st_fb_q;
  logic [SEL_W-1:0]    st_sel_q;
  logic [GAIN_W-1:0]   st_gain_q;
  logic [CUR_W-1:0]    st_cur_q;

  // working registers
  logic [OP_W-1:0]   op_q;
  logic              status_q;
  logic [FB_W-1:0]   fb_q;
  logic [SEL_W-1:0]  sel_q;
  logic [GAIN_W-1:0] gain_q;
  logic [CUR_W-1:0]  cur_q;
  logic [VCO_W-1:0]  vco_q;
  logic [RATE_W-1:0] prod_q;
  logic [RATE_W-1:0] rate_q;

  // output register
  logic              ovalid_q;
  logic [RATE_W-1:0] orate_q;
  logic [FB_W-1:0]   ofb_q;
  logic [SEL_W-1:0]  osel_q;
  logic [GAIN_W-1:0] ogain_q;
  logic [CUR_W-1:0]  ocur_q;
  logic              ostat_q;

  // divider
  pdp_div_req_t     div_req;
  logic             div_busy, div_done;
  logic [DIV_W-1:0] div_quot;

  logic              accept, plan_op, out_free, in_band;
  logic [MHZ_W-1:0]  mhz_w;
  logic [PMHZ_W-1:0] pmhz_w;
  logic [SEL_W-1:0]  sel_w;
  logic [MHZ_W+2:0]  vco_ext;
  logic [VCO_W-1:0]  vco_w;
  logic [16:0]       fb_num;
  logic [RATE_W-1:0] prod_w;
  logic              set_commit, osel_legal;

  pdp_serdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign plan_op     = (req_i.operation == OP_ROUND) || (req_i.operation == OP_SET);
  assign out_free    = !ovalid_q || rsp_o.ready;

  // band selection from the truncated MHz request
  always_comb begin
    mhz_w   = div_quot[MHZ_W-1:0];
    pmhz_w  = div_quot[PMHZ_W-1:0];
    in_band = 1'b1;
    priority if (mhz_w >= VCO_MIN && mhz_w <= VCO_MAX) sel_w = SEL_DIV1;
    else if (mhz_w >= BAND2_MIN && mhz_w < VCO_MIN) sel_w = SEL_DIV2;
    else if (mhz_w >= BAND4_MIN && mhz_w < BAND2_MIN) sel_w = SEL_DIV4;
    else if (mhz_w >= BAND8_MIN && mhz_w < BAND4_MIN) sel_w = SEL_DIV8;
    else begin
      sel_w   = SEL_DIV1;
      in_band = 1'b0;
    end
    vco_ext = {3'b000, mhz_w} << post_shift(sel_w);
    vco_w   = vco_ext[VCO_W-1:0];
  end

  assign fb_num = 17'(vco_q) * 17'(rd_q);
  assign prod_w = RATE_W'(parent_q) * RATE_W'(fb_q);

  // sequencer and divider launch
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.len      = LEN_RATE;
    div_req.dividend = prod_q;
    div_req.divisor  = {{(DVS_W-RD_W){1'b0}}, rd_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (plan_op) begin
            div_req.start    = 1'b1;
            div_req.len      = LEN_MHZ;
            div_req.dividend = {req_i.requested_rate_hz, {(DIV_W-REQ_W){1'b0}}};
            div_req.divisor  = MHZ_HZ;
            state_d          = S_MHZ;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MHZ: begin
        if (div_done) begin
          if (in_band) begin
            div_req.start    = 1'b1;
            div_req.len      = LEN_PMHZ;
            div_req.dividend = {parent_q, {(DIV_W-PARENT_W){1'b0}}};
            div_req.divisor  = MHZ_HZ;
            state_d          = S_PMHZ;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_PMHZ: begin
        if (div_done) begin
          if (pmhz_w == '0) begin
            state_d = S_MUL;
          end else begin
            div_req.start    = 1'b1;
            div_req.len      = LEN_FB;
            div_req.dividend = {fb_num, {(DIV_W-17){1'b0}}};
            div_req.divisor  = {{(DVS_W-PMHZ_W){1'b0}}, pmhz_w};
            state_d          = S_FB;
          end
        end
      end
      S_FB: begin
        if (div_done) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_RSTART;
      end
      S_RSTART: begin
        if (rd_q == '0) begin
          state_d = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_RATE;
        end
      end
      S_RATE: begin
        if (div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
    endcase
  end

  // control state, configuration, stored settings, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      parent_q  <= PARENT_RST;
      rd_q      <= RD_RST;
      st_fb_q   <= '0;
      st_sel_q  <= SEL_DIV1;
      st_gain_q <= '0;
      st_cur_q  <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PARENT_RATE: parent_q <= cfg_wdata_i;
          CFG_REF_DIV:     rd_q     <= cfg_wdata_i[RD_W-1:0];
        endcase
      end
      if (state_q == S_DONE && out_free) begin
        ovalid_q <= 1'b1;
        if (op_q == OP_SET && !status_q) begin
          st_fb_q   <= fb_q;
          st_sel_q  <= sel_q;
          st_gain_q <= gain_q;
          st_cur_q  <= cur_q;
        end
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.operation;
      status_q <= 1'b0;
      fb_q     <= st_fb_q;
      sel_q    <= st_sel_q;
      gain_q   <= st_gain_q;
      cur_q    <= st_cur_q;
    end
    if (state_q == S_MHZ && div_done) begin
      if (in_band) begin
        sel_q  <= sel_w;
        vco_q  <= vco_w;
        gain_q <= gain_of(vco_w);
        cur_q  <= current_of(vco_w);
      end else begin
        status_q <= 1'b1;
      end
    end
    if (state_q == S_PMHZ && div_done && pmhz_w == '0) fb_q <= '0;
    if (state_q == S_FB && div_done) fb_q <= div_quot[FB_W-1:0];
    if (state_q == S_MUL) prod_q <= prod_w;
    if (state_q == S_RSTART && rd_q == '0) rate_q <= '0;
    // post divide is a power of two, so it is a shift of the quotient
    if (state_q == S_RATE && div_done) rate_q <= div_quot >> post_shift(sel_q);
    if (state_q == S_DONE && out_free) begin
      orate_q <= rate_q;
      ofb_q   <= fb_q;
      osel_q  <= sel_q;
      ogain_q <= gain_q;
      ocur_q  <= cur_q;
      ostat_q <= status_q;
    end
  end

  assign rsp_o.valid             = ovalid_q;
  assign rsp_o.rate_hz           = orate_q;
  assign rsp_o.feedback_div      = ofb_q;
  assign rsp_o.post_div_select   = osel_q;
  assign rsp_o.vco_gain_band     = ogain_q;
  assign rsp_o.loop_current_code = ocur_q;
  assign rsp_o.status            = ostat_q;

  // terms for the checks
  assign set_commit = (state_q == S_DONE) && out_free && (op_q == OP_SET) && !status_q;
  assign osel_legal = (osel_q == SEL_DIV1) || (osel_q == SEL_DIV2) || (osel_q == SEL_DIV4) ||
                      (osel_q == SEL_DIV8);

  // checks
  `PDP_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, div_req.start, !div_busy, "start while busy")
  `PDP_ASSERT_NXT(a_set_fb, clk_i, rst_ni, set_commit, st_fb_q == $past(fb_q), "fb not stored")
  `PDP_ASSERT_NXT(a_set_sel, clk_i, rst_ni, set_commit, st_sel_q == $past(sel_q), "sel not stored")
  `PDP_ASSERT_IMP(a_sel_legal, clk_i, rst_ni, ovalid_q, osel_legal, "illegal post divider select")

endmodule

// File: bench/pll_divider_planner_unit_checker.sv
`timescale 1ns / 1ps

module pll_divider_planner_unit_checker import pdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PARENT_W-1:0]  cfg_wdata_i,
  pdp_in_if                    req_i,
  pdp_out_if                   rsp_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  // keep the log short when the block is badly off
  localparam int unsigned REPORT_LIMIT = 100;

  typedef struct packed {
    logic [RATE_W-1:0] rate_hz;
    logic [FB_W-1:0]   feedback_div;
    logic [SEL_W-1:0]  post_sel;
    logic [GAIN_W-1:0] gain_band;
    logic [CUR_W-1:0]  loop_current;
    logic              status;
  } plan_t;

  // shadow of the registers and of the stored divider settings
  logic [PARENT_W-1:0] parent_hz;
  logic [RD_W-1:0]     ref_div;
  plan_t               stored;
  plan_t               plan_q[$];
  int unsigned         fails;

  function automatic int unsigned post_divide(logic [SEL_W-1:0] sel);
    case (sel)
      SEL_DIV1: return 1;
      SEL_DIV2: return 2;
      SEL_DIV4: return 4;
      SEL_DIV8: return 8;
      default:  return 0;
    endcase
  endfunction

  // output rate from a feedback divide and post select, each division truncating
  function automatic logic [RATE_W-1:0] rate_for(logic [FB_W-1:0] fb, logic [SEL_W-1:0] sel);
    logic [63:0] r;
    int unsigned pd;
    pd = post_divide(sel);
    if (ref_div == '0 || pd == 0) return '0;
    r = 64'(parent_hz) * 64'(fb);
    r = r / 64'(ref_div) / 64'(pd);
    return r[RATE_W-1:0];
  endfunction

  // the stored settings reported as a result
  function automatic plan_t stored_result(logic status);
    plan_t p;
    p = stored;
    p.rate_hz = rate_for(stored.feedback_div, stored.post_sel);
    p.status = status;
    return p;
  endfunction

  // planned settings for a request; status set when it falls outside every band
  function automatic plan_t plan_request(logic [REQ_W-1:0] req_hz);
    plan_t p;
    int unsigned mhz, vco, pmhz, fb;
    p = '0;
    mhz = req_hz / MHZ_HZ;
    if (mhz >= VCO_MIN && mhz <= VCO_MAX) p.post_sel = SEL_DIV1;
    else if (mhz >= BAND2_MIN && mhz < VCO_MIN) p.post_sel = SEL_DIV2;
    else if (mhz >= BAND4_MIN && mhz < BAND2_MIN) p.post_sel = SEL_DIV4;
    else if (mhz >= BAND8_MIN && mhz < BAND4_MIN) p.post_sel = SEL_DIV8;
    else begin
      p.status = 1'b1;
      return p;
    end
    vco = mhz * post_divide(p.post_sel);
    pmhz = parent_hz / MHZ_HZ;
    fb = (pmhz == 0) ? 0 : (vco * ref_div) / pmhz;
    p.feedback_div = FB_W'(fb);
    p.rate_hz = rate_for(p.feedback_div, p.post_sel);
    // one band step per threshold the vco lies above
    p.gain_band = GAIN_W'(1 + (vco > 1350) + (vco > 1550) + (vco > 1750) + (vco > 1950)
                          + (vco > 2150) + (vco > 2400));
    p.loop_current = CUR_W'(2 + (vco > 1500) + (vco > 1800) + (vco > 2100) + (vco > 2400));
    return p;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= REPORT_LIMIT)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plan_t p;
    plan_t want;
    logic  is_change;
    if (!rst_ni) begin
      parent_hz = PARENT_RST;
      ref_div = RD_RST;
      stored = '0;
      plan_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PARENT_RATE: parent_hz = cfg_wdata_i;
          CFG_REF_DIV:     ref_div = cfg_wdata_i[RD_W-1:0];
          default: ;
        endcase
      end

      // result transfer, checked before a request taken at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (plan_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: result expected none actual rate_hz %0d", $time, rsp_i.rate_hz);
        end else begin
          want = plan_q.pop_front();
          compare_field("rate_hz", want.rate_hz, rsp_i.rate_hz);
          compare_field("feedback_div", want.feedback_div, rsp_i.feedback_div);
          compare_field("post_div_select", want.post_sel, rsp_i.post_div_select);
          compare_field("vco_gain_band", want.gain_band, rsp_i.vco_gain_band);
          compare_field("loop_current_code", want.loop_current, rsp_i.loop_current_code);
          compare_field("status", want.status, rsp_i.status);
        end
      end

      // request transfer: predict its result and update the stored settings
      if (req_i.valid && req_i.ready) begin
        p = plan_request(req_i.requested_rate_hz);
        is_change = (req_i.operation == OP_ROUND || req_i.operation == OP_SET);
        if (is_change && !p.status) begin
          if (req_i.operation == OP_SET) stored = p;
          plan_q.push_back(p);
        end else begin
          plan_q.push_back(stored_result(is_change));
        end
      end

      fail_count_o <= fails;
      pending_o <= plan_q.size();
    end
  end

endmodule

// File: bench/pll_divider_planner_unit_test.sv
`timescale 1ns / 1ps

module pll_divider_planner_unit_test import pdp_pkg::*; ();

  // operation code with no function of its own, handled as a query
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 130;
  localparam int unsigned PRESSURE_PHASE  = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 250;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PARENT_W-1:0]  cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_off_asks;
  int unsigned hold_off_done;

  pdp_in_if  req_if ();
  pdp_out_if rsp_if ();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pll_divider_planner_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  pll_divider_planner_unit_checker rate_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pll_divider_planner_unit: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_asks != hold_off_done) begin
        hold_off_done = hold_off_asks;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] hz);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.requested_rate_hz <= hz;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // both registers, back to back; unused upper bits of the divider write are noise
  task automatic write_config(input logic [PARENT_W-1:0] parent_hz, input logic [RD_W-1:0] rd);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PARENT_RATE;
    cfg_wdata_i <= parent_hz;
    @(posedge clk_i);
    cfg_idx_i <= CFG_REF_DIV;
    cfg_wdata_i <= PARENT_W'(($urandom() << RD_W) | 32'(rd));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned         r;
    int unsigned         mhz;
    logic [OP_W-1:0]     op;
    logic [REQ_W-1:0]    hz;
    logic [PARENT_W-1:0] parent;
    logic [RD_W-1:0]     rd;

    req_if.valid <= 1'b0;
    req_if.operation <= OP_QUERY;
    req_if.requested_rate_hz <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_PARENT_RATE;
    cfg_wdata_i <= '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // band edges under the reset configuration
    send_request(OP_QUERY, 32'd0);
    send_request(OP_ROUND, 32'd1200000000);
    send_request(OP_ROUND, 32'd2500999999);
    send_request(OP_ROUND, 32'd2501000000);
    send_request(OP_ROUND, 32'd1199999999);
    send_request(OP_ROUND, 32'd600000000);
    send_request(OP_ROUND, 32'd599999999);
    send_request(OP_ROUND, 32'd300000000);
    send_request(OP_ROUND, 32'd299999999);
    send_request(OP_ROUND, 32'd150000000);
    send_request(OP_ROUND, 32'd149999999);
    // set, then out-of-band requests that must leave it alone
    send_request(OP_SET, 32'd1000000000);
    send_request(OP_UNUSED, 32'hFFFFFFFF);
    send_request(OP_SET, 32'hFFFFFFFF);
    send_request(OP_ROUND, 32'd0);
    send_request(OP_QUERY, 32'd0);

    // parent below one MHz plans a zero feedback divide
    wait_idle();
    write_config(27'd999999, 5'd1);
    send_request(OP_SET, 32'd2000000000);
    send_request(OP_QUERY, 32'd0);

    // zero reference divider reports every rate as zero
    wait_idle();
    write_config(27'd25000000, 5'd0);
    send_request(OP_ROUND, 32'd1800000000);
    send_request(OP_QUERY, 32'd0);
    send_request(OP_SET, 32'd160000000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin parent = 27'd25000000; rd = 5'd1; end
        1: begin parent = 27'd1000000; rd = 5'd31; end
        2: begin parent = 27'd100000000; rd = 5'd31; end
        3: begin parent = 27'd100000000; rd = 5'd1; end
        5: begin parent = 27'h7FFFFFF; rd = RD_W'($urandom_range(31, 1)); end
        7: begin parent = 27'd1000000; rd = 5'd1; end
        default: begin
          parent = PARENT_W'($urandom_range(100000000, 1000000));
          rd = RD_W'($urandom_range(31, 1));
        end
      endcase
      write_config(parent, rd);

      // idle pattern of this phase
      case (p % 4)
        0: begin send_idle_pct = 0; sink_stall_pct <= 0; end
        1: begin send_idle_pct = 57; sink_stall_pct <= 0; end
        2: begin send_idle_pct = 0; sink_stall_pct <= 57; end
        default: begin send_idle_pct = 14; sink_stall_pct <= 14; end
      endcase
      if (p == PRESSURE_PHASE) hold_off_asks <= hold_off_asks + 1;

      repeat (ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 5) op = OP_QUERY;
        else if (r < 10) op = OP_UNUSED;
        else if (r < 50) op = OP_ROUND;
        else op = OP_SET;

        r = $urandom_range(99);
        if (r < 60) begin
          // in band, random fraction of a MHz
          case ($urandom_range(3))
            0: mhz = $urandom_range(2500, 1200);
            1: mhz = $urandom_range(1199, 600);
            2: mhz = $urandom_range(599, 300);
            default: mhz = $urandom_range(299, 150);
          endcase
          hz = mhz * 1000000 + $urandom_range(999999);
        end else if (r < 75) begin
          // on or just past a band edge or a gain or loop current threshold
          case ($urandom_range(10))
            0: mhz = 1200;
            1: mhz = 1350;
            2: mhz = 1500;
            3: mhz = 1550;
            4: mhz = 1750;
            5: mhz = 1800;
            6: mhz = 1950;
            7: mhz = 2100;
            8: mhz = 2150;
            9: mhz = 2400;
            default: mhz = 2500;
          endcase
          mhz = mhz + $urandom_range(1);
          hz = mhz * 1000000 + $urandom_range(999999);
        end else begin
          hz = $urandom();
        end
        send_request(op, hz);
      end
    end

    // drain, then watch for stray results
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("pll_divider_planner_unit: match");
    end else begin
      $display("pll_divider_planner_unit: mismatch");
    end
    $finish;
  end

endmodule
